FILE: hw/rtl/stw_pkg.sv
// Shared types, constants and the regeneration mix function of the twister generator.
package stw_pkg;

  localparam int ROW_W = 128;
  localparam int WORD_W = 32;
  localparam int VALUE_W = 54;
  localparam int LAG_OFFSET = 89;

  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_WORD = 2'd1;
  localparam logic [1:0] OP_FRAC = 2'd2;

  localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;

  localparam logic [ROW_W-1:0] LANE_MASK =
    {32'hfefe7bef, 32'heffffbff, 32'hfffbffff, 32'h7f7fffff};

  localparam logic [VALUE_W-1:0] FRAC_ONE = 54'h0010000000000000;

  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] data;
  } stw_row_wr_t;

  function automatic logic [ROW_W-1:0] stw_mix(input logic [ROW_W-1:0] a,
                                               input logic [ROW_W-1:0] b,
                                               input logic [ROW_W-1:0] c,
                                               input logic [ROW_W-1:0] d);
    logic [ROW_W-1:0] sh;
    logic [ROW_W-1:0] bm;
    logic [ROW_W-1:0] cs;
    logic [ROW_W-1:0] rd;
    sh = a << 8;
    for (int k = 0; k < 4; k++) begin
      bm[32*k +: 32] = (b[32*k +: 32] >> 3) & LANE_MASK[32*k +: 32];
      cs[32*k +: 32] = (c[32*k +: 32] << 18) ^ (c[32*k +: 32] >> 2);
    end
    rd = {d[63:32], d[31:0], d[95:64], d[127:96]};
    return a ^ sh ^ bm ^ cs ^ rd;
  endfunction

endpackage

FILE: hw/rtl/stw_in_if.sv
// Request channel: opcode and seed word with valid/ready.
interface stw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] seed_value;

  modport source (output valid, output opcode, output seed_value, input ready);
  modport sink (input valid, input opcode, input seed_value, output ready);
endinterface

FILE: hw/rtl/stw_out_if.sv
// Result channel: drawn value with valid/ready.
interface stw_out_if;
  logic        valid;
  logic        ready;
  logic [53:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

FILE: hw/rtl/simd_twister_rng_19937.sv
// A draw that finds words left reads the row memory on acceptance, then selects and forms the
// value into a registered result. A draw that runs the store out first regenerates it
// through the load, init, run and accumulator states, one read-modify-write of a row per
// cycle on the two-read, one-write row memory, once per 620 word draws or 310 fraction draws.
// Seeding expands one word per cycle through a single 32x32 multiplier, with no result. Reset
// needs no clearing pass: per-row valid bits make unwritten rows read as zero.
module simd_twister_rng_19937
  import stw_pkg::*;
#(
  parameter int STORE_WORDS = 155
) (
  input  logic       clk,
  input  logic       rst,
  stw_in_if.sink     req,
  stw_out_if.source  rsp
);

  localparam int DEPTH = STORE_WORDS + 1;
  localparam int AW = $clog2(DEPTH);
  localparam int WPW = $clog2(4 * STORE_WORDS + 1);
  localparam int DPW = $clog2(2 * STORE_WORDS + 1);
  localparam logic [WPW-1:0] WORDS = WPW'(4 * STORE_WORDS);
  localparam logic [DPW-1:0] DWORDS = DPW'(2 * STORE_WORDS);
  localparam logic [AW-1:0] ACC_ROW = AW'(STORE_WORDS);
  localparam logic [AW-1:0] LAST_ROW = AW'(STORE_WORDS - 1);
  localparam logic [AW-1:0] LAG_ROW = AW'(LAG_OFFSET % STORE_WORDS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_RUN = 3'd4;
  localparam logic [2:0] S_ACC = 3'd5;
  localparam logic [2:0] S_FETCH = 3'd6;

  logic [2:0]         state;
  logic [1:0]         op;
  logic [WPW-1:0]     wpos;
  logic [DPW-1:0]     dpos;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      bidx;
  logic [ROW_W-1:0]   acc;
  logic [ROW_W-1:0]   prev;
  logic               out_valid;
  logic [VALUE_W-1:0] out_value;

  logic               accept;
  logic               need_regen;
  logic               seed_start;
  logic               seed_done;
  stw_row_wr_t        seed_wr;
  logic [AW-1:0]      seed_addr;
  stw_row_wr_t        wr;
  logic [AW-1:0]      waddr;
  logic               re_a;
  logic               re_b;
  logic [AW-1:0]      raddr_a;
  logic [AW-1:0]      raddr_b;
  logic [ROW_W-1:0]   rdata_a;
  logic [ROW_W-1:0]   rdata_b;
  logic [ROW_W-1:0]   mix_r;
  logic [AW-1:0]      bidx_next;
  logic [WORD_W-1:0]  word_sel;
  logic [WORD_W-1:0]  hi_sel;
  logic [WORD_W-1:0]  lo_sel;
  logic [VALUE_W-1:0] result;
  logic               out_free;

  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;
  assign need_regen = ((req.opcode == OP_WORD) && (wpos >= WORDS)) ||
                      ((req.opcode == OP_FRAC) && (dpos >= DWORDS));
  assign seed_start = accept && (req.opcode == OP_SEED);

  assign mix_r = stw_mix(rdata_a, rdata_b, prev, acc);
  assign bidx_next = (bidx == LAST_ROW) ? '0 : bidx + AW'(1);

  assign word_sel = rdata_a[32*wpos[1:0] +: 32];
  assign hi_sel = rdata_a[64*dpos[0] +: 32];
  assign lo_sel = rdata_a[64*dpos[0] + 32 +: 32];
  assign result = (op == OP_WORD) ? VALUE_W'(word_sel)
                                  : FRAC_ONE - VALUE_W'({hi_sel[19:0], lo_sel});
  assign out_free = !out_valid || rsp.ready;

  assign rsp.valid = out_valid;
  assign rsp.value = out_value;

  stw_seeder #(.DEPTH(DEPTH)) u_seeder (
    .clk   (clk),
    .rst   (rst),
    .start (seed_start),
    .seed  (req.seed_value),
    .wr    (seed_wr),
    .waddr (seed_addr),
    .done  (seed_done)
  );

  stw_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .waddr   (waddr),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    wr.we = 1'b0;
    wr.data = mix_r;
    waddr = idx;
    re_a = 1'b0;
    raddr_a = '0;
    re_b = 1'b0;
    raddr_b = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && !need_regen &&
            ((req.opcode == OP_WORD) || (req.opcode == OP_FRAC))) begin
          re_a = 1'b1;
          raddr_a = (req.opcode == OP_WORD) ? AW'(wpos >> 2) : AW'(dpos >> 1);
        end
      end
      S_SEED: begin
        wr = seed_wr;
        waddr = seed_addr;
      end
      S_LOAD: begin
        re_a = 1'b1;
        raddr_a = ACC_ROW;
        re_b = 1'b1;
        raddr_b = LAST_ROW;
      end
      S_INIT: begin
        re_a = 1'b1;
        raddr_a = '0;
        re_b = 1'b1;
        raddr_b = LAG_ROW;
      end
      S_RUN: begin
        wr.we = 1'b1;
        if (idx != LAST_ROW) begin
          re_a = 1'b1;
          raddr_a = idx + AW'(1);
          re_b = 1'b1;
          raddr_b = bidx_next;
        end
      end
      S_ACC: begin
        wr.we = 1'b1;
        wr.data = acc;
        waddr = ACC_ROW;
        re_a = 1'b1;
        raddr_a = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_SEED;
      wpos <= WORDS;
      dpos <= DWORDS;
      idx <= '0;
      bidx <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FETCH) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= req.opcode;
            if (req.opcode == OP_SEED) begin
              state <= S_SEED;
            end else if ((req.opcode == OP_WORD) || (req.opcode == OP_FRAC)) begin
              state <= need_regen ? S_LOAD : S_FETCH;
            end
          end
        end
        S_SEED: begin
          if (seed_done) begin
            wpos <= WORDS;
            dpos <= DWORDS;
            state <= S_IDLE;
          end
        end
        S_LOAD: state <= S_INIT;
        S_INIT: begin
          idx <= '0;
          bidx <= LAG_ROW;
          state <= S_RUN;
        end
        S_RUN: begin
          idx <= idx + AW'(1);
          bidx <= bidx_next;
          if (idx == LAST_ROW) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          wpos <= '0;
          if (op == OP_FRAC) begin
            dpos <= '0;
          end
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (out_free) begin
            if (op == OP_WORD) begin
              wpos <= wpos + WPW'(1);
            end else begin
              dpos <= dpos + DPW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_INIT) begin
      acc <= rdata_a;
      prev <= rdata_b;
    end else if (state == S_RUN) begin
      acc <= acc ^ mix_r;
      prev <= mix_r;
    end
    if ((state == S_FETCH) && out_free) begin
      out_value <= result;
    end
  end

  a_word_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) && (op == OP_WORD) |-> wpos < WORDS)
    else $error("word fetch with position past end of store");

  a_frac_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) && (op == OP_FRAC) |-> dpos < DWORDS)
    else $error("fraction fetch with position past end of store");

  a_exhausted_regen: assert property (@(posedge clk) disable iff (rst)
    accept && need_regen |=> state == S_LOAD)
    else $error("exhausted draw did not start regeneration");

  a_seed_positions: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEED) && seed_done |=> (wpos == WORDS) && (dpos == DWORDS))
    else $error("seeding did not mark store exhausted");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) || (state == S_FETCH) |-> !wr.we)
    else $error("row write outside seeding or regeneration");

endmodule

FILE: hw/rtl/stw_store.sv
// Row memory: one write port, two registered read ports, per-row valid bits.
module stw_store
  import stw_pkg::*;
#(
  parameter int DEPTH = 156,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  stw_row_wr_t      wr,
  input  logic [AW-1:0]    waddr,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [ROW_W-1:0] rdata_a,
  output logic [ROW_W-1:0] rdata_b
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  logic [ROW_W-1:0] mem_a;
  logic [ROW_W-1:0] mem_b;
  logic             hit_a;
  logic             hit_b;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
    if (re_a) begin
      mem_a <= mem[raddr_a];
    end
    if (re_b) begin
      mem_b <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      hit_a <= 1'b0;
      hit_b <= 1'b0;
    end else begin
      if (wr.we) begin
        row_valid[waddr] <= 1'b1;
      end
      if (re_a) begin
        hit_a <= row_valid[raddr_a];
      end
      if (re_b) begin
        hit_b <= row_valid[raddr_b];
      end
    end
  end

  // rows never written since reset read as zero
  assign rdata_a = hit_a ? mem_a : '0;
  assign rdata_b = hit_b ? mem_b : '0;

endmodule

FILE: hw/rtl/stw_seeder.sv
// Seed expander: one 32-bit word per cycle, one row write per four words.
module stw_seeder
  import stw_pkg::*;
#(
  parameter int DEPTH = 156,
  localparam int AW = $clog2(DEPTH),
  localparam int ALL_WORDS = 4 * DEPTH,
  localparam int CW = $clog2(ALL_WORDS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] seed,
  output stw_row_wr_t       wr,
  output logic [AW-1:0]     waddr,
  output logic              done
);

  localparam logic [CW-1:0] LAST = CW'(ALL_WORDS - 1);

  logic                busy;
  logic [CW-1:0]       cnt;
  logic [WORD_W-1:0]   x;
  logic [3*WORD_W-1:0] row;
  logic [WORD_W-1:0]   prod;
  logic [WORD_W-1:0]   xn;

  assign prod = SEED_MULT * (x ^ (x >> 30));
  assign xn = prod + WORD_W'(cnt);

  assign wr.we = busy && (cnt[1:0] == 2'd3);
  assign wr.data = {xn, row};
  assign waddr = AW'(cnt >> 2);
  assign done = busy && (cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(1);
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= seed;
      row[31:0] <= seed;
    end else if (busy) begin
      x <= xn;
      unique case (cnt[1:0])
        2'd0: row[31:0] <= xn;
        2'd1: row[63:32] <= xn;
        2'd2: row[95:64] <= xn;
        default: ;
      endcase
    end
  end

endmodule

FILE: tb/sv/tb_simd_twister_rng_19937.sv
// Self-checking testbench for the twister generator: seeds, word draws and fraction draws.
module tb_simd_twister_rng_19937;
  import stw_pkg::*;

  localparam int ROWS = 155;
  localparam int ROW_WORDS = ROWS * 4;
  localparam int ROW_DWORDS = ROWS * 2;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int IDLE_PCT = 27;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TAIL_CYCLES = 800;
  localparam int HOLD_AT = 650;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [1:0]  opcode;
    logic [31:0] seed_value;
    bit          drain_first;
  } rng_req_t;

  logic clk;
  logic rst;

  stw_in_if  req_if ();
  stw_out_if rsp_if ();

  simd_twister_rng_19937 dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  logic [ROW_W-1:0]   model_rows [ROWS+1];
  int unsigned        word_pos;
  int unsigned        dword_pos;
  rng_req_t           pending_reqs [$];
  logic [VALUE_W-1:0] expected_draws [$];
  int                 n_offered = 0;
  int                 n_checked = 0;
  int                 n_errors = 0;
  int                 cycle_count = 0;
  bit                 timed_out;

  function automatic logic [WORD_W-1:0] stored_word(int unsigned w);
    return model_rows[w / 4][32*(w % 4) +: 32];
  endfunction

  function automatic void renew_rows();
    logic [ROW_W-1:0]  acc;
    logic [ROW_W-1:0]  prev;
    logic [ROW_W-1:0]  a;
    logic [ROW_W-1:0]  b;
    logic [ROW_W-1:0]  nv;
    logic [WORD_W-1:0] c;
    int                src;
    acc = model_rows[ROWS];
    prev = model_rows[ROWS-1];
    for (int i = 0; i < ROWS; i++) begin
      a = model_rows[i];
      b = model_rows[(i + LAG_OFFSET) % ROWS];
      nv = a ^ (a << 8);
      for (int k = 0; k < 4; k++) begin
        c = prev[32*k +: 32];
        // accumulator lanes enter as (3, 2, 0, 1)
        src = (k == 0) ? 3 : (k == 1) ? 2 : (k == 2) ? 0 : 1;
        nv[32*k +: 32] = nv[32*k +: 32]
                         ^ ((b[32*k +: 32] >> 3) & LANE_MASK[32*k +: 32])
                         ^ (c << 18) ^ (c >> 2) ^ acc[32*src +: 32];
      end
      model_rows[i] = nv;
      prev = nv;
      acc = acc ^ nv;
    end
    model_rows[ROWS] = acc;
  endfunction

  function automatic void seed_rows(logic [31:0] s);
    logic [31:0] x;
    x = s;
    model_rows[0][31:0] = x;
    for (int unsigned i = 1; i < 4 * (ROWS + 1); i++) begin
      x = SEED_MULT * (x ^ (x >> 30)) + 32'(i);
      model_rows[i / 4][32*(i % 4) +: 32] = x;
    end
    word_pos = ROW_WORDS;
    dword_pos = ROW_DWORDS;
  endfunction

  function automatic void twister_step(logic [1:0] opcode, logic [31:0] seed_value);
    logic [63:0] pair;
    case (opcode)
      OP_SEED: begin
        seed_rows(seed_value);
      end
      OP_WORD: begin
        if (word_pos >= ROW_WORDS) begin
          renew_rows();
          word_pos = 0;
        end
        expected_draws.push_back(VALUE_W'(stored_word(word_pos)));
        word_pos++;
      end
      OP_FRAC: begin
        if (dword_pos >= ROW_DWORDS) begin
          renew_rows();
          word_pos = 0;
          dword_pos = 0;
        end
        pair = {stored_word(2 * dword_pos), stored_word(2 * dword_pos + 1)};
        expected_draws.push_back(FRAC_ONE - VALUE_W'(pair[51:0]));
        dword_pos++;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_req(logic [1:0] opcode, logic [31:0] seed_value, bit drain);
    rng_req_t r;
    r.opcode = opcode;
    r.seed_value = seed_value;
    r.drain_first = drain;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [1:0] pick_draw(int word_pct, int frac_pct);
    int r;
    r = $urandom_range(99, 0);
    if (r < word_pct) return OP_WORD;
    if (r < word_pct + frac_pct) return OP_FRAC;
    return OP_NONE;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // driver
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        twister_step(req_if.opcode, req_if.seed_value);
      end
      if (!req_if.valid || req_if.ready) begin
        offer = pending_reqs.size() != 0;
        if (offer && pending_reqs[0].drain_first && expected_draws.size() != 0) begin
          offer = 1'b0;
        end
        if (offer && !(n_offered >= 400 && n_offered < 600)
            && $urandom_range(99, 0) < IDLE_PCT) begin
          offer = 1'b0;
        end
        if (offer) begin
          req_if.opcode <= pending_reqs[0].opcode;
          req_if.seed_value <= pending_reqs[0].seed_value;
          void'(pending_reqs.pop_front());
          n_offered++;
        end
        req_if.valid <= offer;
      end
    end
  end

  // monitor and result-side stalls
  always @(posedge clk) begin
    logic [VALUE_W-1:0] want;
    int                 hold_left;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_draws.size() == 0) begin
          $error("value: expected none, actual %0h", rsp_if.value);
          n_errors++;
        end else begin
          want = expected_draws.pop_front();
          if (rsp_if.value !== want) begin
            $error("value: expected %0h, actual %0h", want, rsp_if.value);
            n_errors++;
          end
        end
        n_checked++;
        if (n_checked == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= (n_checked >= 200 && n_checked < 400)
                        || $urandom_range(99, 0) >= IDLE_PCT;
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.opcode = OP_NONE;
    req_if.seed_value = '0;
    rsp_if.ready = 1'b0;
    foreach (model_rows[i]) model_rows[i] = '0;
    word_pos = ROW_WORDS;
    dword_pos = ROW_DWORDS;

    // unseeded draws: zero words, full fraction
    add_req(OP_WORD, $urandom(), 1'b0);
    add_req(OP_FRAC, $urandom(), 1'b0);
    add_req(OP_NONE, 32'hffffffff, 1'b0);
    add_req(OP_WORD, 32'h0, 1'b0);
    add_req(OP_SEED, 32'h0, 1'b0);
    add_req(OP_WORD, $urandom(), 1'b0);
    add_req(OP_WORD, $urandom(), 1'b0);
    add_req(OP_WORD, $urandom(), 1'b0);
    // fraction after a word refill still finds its own position exhausted
    add_req(OP_FRAC, $urandom(), 1'b0);
    add_req(OP_FRAC, $urandom(), 1'b0);
    add_req(OP_WORD, $urandom(), 1'b0);
    add_req(OP_SEED, 32'hffffffff, 1'b1);
    add_req(OP_FRAC, $urandom(), 1'b0);
    add_req(OP_WORD, $urandom(), 1'b0);
    add_req(OP_WORD, $urandom(), 1'b0);
    add_req(OP_FRAC, $urandom(), 1'b0);
    add_req(OP_NONE, $urandom(), 1'b0);
    add_req(OP_SEED, 32'd5489, 1'b0);
    add_req(OP_WORD, $urandom(), 1'b0);
    add_req(OP_FRAC, $urandom(), 1'b0);

    // long word-heavy run: crosses the word refill point
    add_req(OP_SEED, $urandom(), 1'b0);
    repeat (700) add_req(pick_draw(90, 6), $urandom(), 1'b0);
    // fraction-heavy run after a full drain
    add_req(OP_SEED, $urandom(), 1'b1);
    repeat (360) add_req(pick_draw(6, 90), $urandom(), 1'b0);
    // anything goes
    repeat (60) add_req(2'($urandom_range(3, 0)), $urandom(), 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while ((pending_reqs.size() != 0 || req_if.valid || expected_draws.size() != 0)
           && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    timed_out = cycle_count >= CYCLE_LIMIT;
    if (timed_out) $error("timeout after %0d cycles", cycle_count);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (!timed_out && n_errors == 0) begin
      $display("tb_simd_twister_rng_19937: PASS");
    end else begin
      $display("tb_simd_twister_rng_19937: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/stw_pkg.sv
hw/rtl/stw_in_if.sv
hw/rtl/stw_out_if.sv
hw/rtl/stw_store.sv
hw/rtl/stw_seeder.sv
hw/rtl/simd_twister_rng_19937.sv
tb/sv/tb_simd_twister_rng_19937.sv
